@@ sv/bfha_pkg.sv @@
package bfha_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT_H,
		ST_INIT_F,
		ST_WALK_A,
		ST_A_DEC,
		ST_A_S0,
		ST_A_S1,
		ST_A_S2,
		ST_A_J0,
		ST_A_JN,
		ST_WALK_F,
		ST_F_NX,
		ST_F_PRV,
		ST_F_W0,
		ST_F_W1
	} state_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_BAD_SIZE = 2'd1,
		STS_NO_SPACE = 2'd2,
		STS_BAD_PTR  = 2'd3
	} status_t;

	localparam int OFF_W = 13;
	localparam int WORD_W = 13;
	localparam int REQ_W = 16;
	localparam int NEED_W = 17;
	localparam logic [OFF_W-1:0] HDR_BYTES = 13'd4;
	localparam logic [OFF_W-1:0] MIN_BLOCK = 13'd8;
	localparam logic [OFF_W-1:0] ADDR_LIMIT = 13'd4096;
	localparam logic [OFF_W-1:0] REGION_RESET = 13'd4096;

endpackage

@@ sv/best_fit_heap_allocator_unit.sv @@
// Best-fit heap allocator over a boundary-tagged word memory.
//
// Channels: a command item (operation, request_bytes, payload_addr) is taken
// at a clock edge where start is high and busy is low. Each item yields one
// result (result_addr, status) shown for exactly one cycle while done is
// high; the receiver cannot hold it off, so results are never stalled.
// The region_bytes register is written on cfg_valid & cfg_ready; ready is
// high only while the block is idle, and a write reinitialises the heap.
//
// Memory and walks: the heap state lives in one synchronous RAM with a registered
// read port. Block walks read one header per cycle, so an allocate walks the
// blocks of the heap and a free walks the blocks up to the freed one. Bad
// size items and pointers that fail the null, alignment or range checks
// finish from idle with no walk; a pointer rejected by the walk costs the
// walk up to the point of rejection. The header walk through the RAM read
// port sets how long an item takes.
//
// Reset: arst_n clears control state and the region register to 4096;
// the block then writes the initial header and footer (busy high) before
// taking items. A config write runs the same header and footer writes.
module best_fit_heap_allocator_unit #(
	parameter int HEAP_WORDS = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   operation,
	input  logic [15:0]            request_bytes,
	input  logic [11:0]            payload_addr,
	output logic                   done,
	output logic [11:0]            result_addr,
	output logic [1:0]             status,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [12:0]            region_bytes
);
	import bfha_pkg::*;

	// only the first 4096 bytes are addressable
	localparam int DEPTH = (HEAP_WORDS < 1024) ? HEAP_WORDS : 1024;
	localparam int AW = $clog2(DEPTH);
	localparam logic [OFF_W-1:0] CAP = OFF_W'(DEPTH * 4);

	state_t state_q, state_d;

	logic [OFF_W-1:0]  region_q, region_d;
	logic [NEED_W-1:0] need_q, need_d;
	logic [OFF_W-1:0]  h_q, h_d;
	logic [OFF_W-1:0]  cur_q, cur_d;
	logic              found_q, found_d;
	logic [OFF_W-1:0]  best_q, best_d;
	logic [OFF_W-1:0]  bsize_q, bsize_d;
	logic              bprev_q, bprev_d;
	logic [OFF_W-1:0]  prev_q, prev_d;
	logic              havep_q, havep_d;
	logic              pfree_q, pfree_d;
	logic              ppb_q, ppb_d;
	logic [OFF_W-1:0]  size_q, size_d;
	logic [OFF_W-1:0]  start_q, start_d;
	logic              pbits_q, pbits_d;

	logic              done_q;
	logic [11:0]       raddr_q;
	logic [1:0]        status_q;
	logic              fin;
	logic [11:0]       fin_addr;
	status_t           fin_status;

	logic [WORD_W-1:0] heap_mem [DEPTH];
	logic [WORD_W-1:0] rd_data_s1;
	logic [OFF_W-1:0]  rd_off, wr_off;
	logic [WORD_W-1:0] wr_data;
	logic              wr_en;

	logic [OFF_W-1:0]  region_used;
	logic [OFF_W-1:0]  hdr_size;
	logic [OFF_W:0]    next_off;
	logic              hdr_bad;
	logic [OFF_W-1:0]  rem;
	logic [OFF_W:0]    nx_off;
	logic [NEED_W-1:0] need_calc;
	logic              ptr_bad;

	// round the configured region down to a word multiple and clamp it to [8, capacity]
	always_comb begin
		region_used = {region_q[12:2], 2'b00};
		if (region_used < MIN_BLOCK)
			region_used = MIN_BLOCK;
		if (region_used > CAP)
			region_used = CAP;
		if (region_used > ADDR_LIMIT)
			region_used = ADDR_LIMIT;
	end

	// header decode of the word just read
	assign hdr_size = {rd_data_s1[12:2], 2'b00};
	assign next_off = {1'b0, cur_q} + {1'b0, hdr_size};
	assign hdr_bad  = (hdr_size < MIN_BLOCK) || (next_off > {1'b0, region_used});
	assign rem      = bsize_q - need_q[OFF_W-1:0];
	assign nx_off   = (state_q == ST_F_NX) ? {1'b0, h_q} + {1'b0, size_q}
	                                       : {1'b0, best_q} + {1'b0, bsize_q};
	assign need_calc = ((({1'b0, request_bytes}) + NEED_W'(3)) & ~NEED_W'(3))
	                   + NEED_W'(4);
	assign ptr_bad = (payload_addr == 12'd0) || (payload_addr[1:0] != 2'b00)
	                 || ({1'b0, payload_addr} >= region_used);

	always_comb begin
		state_d   = state_q;
		region_d  = region_q;
		need_d    = need_q;
		h_d       = h_q;
		cur_d     = cur_q;
		found_d   = found_q;
		best_d    = best_q;
		bsize_d   = bsize_q;
		bprev_d   = bprev_q;
		prev_d    = prev_q;
		havep_d   = havep_q;
		pfree_d   = pfree_q;
		ppb_d     = ppb_q;
		size_d    = size_q;
		start_d   = start_q;
		pbits_d   = pbits_q;
		fin       = 1'b0;
		fin_addr  = 12'd0;
		fin_status = STS_OK;
		rd_off    = '0;
		wr_en     = 1'b0;
		wr_off    = '0;
		wr_data   = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (cfg_valid) begin
					region_d = region_bytes;
					state_d  = ST_INIT_H;
				end else if (start) begin
					cur_d   = '0;
					found_d = 1'b0;
					havep_d = 1'b0;
					rd_off  = '0;
					if (operation == OP_FREE) begin
						h_d = {1'b0, payload_addr} - HDR_BYTES;
						if (ptr_bad) begin
							fin        = 1'b1;
							fin_status = STS_BAD_PTR;
						end else begin
							state_d = ST_WALK_F;
						end
					end else if (request_bytes == '0) begin
						fin        = 1'b1;
						fin_status = STS_BAD_SIZE;
					end else begin
						need_d  = need_calc;
						state_d = ST_WALK_A;
					end
				end
			end
			ST_INIT_H: begin
				wr_en   = 1'b1;
				wr_off  = '0;
				wr_data = region_used | WORD_W'(2);
				state_d = ST_INIT_F;
			end
			ST_INIT_F: begin
				wr_en   = 1'b1;
				wr_off  = region_used - HDR_BYTES;
				wr_data = region_used;
				state_d = ST_IDLE;
			end
			ST_WALK_A: begin
				if (hdr_bad) begin
					state_d = ST_A_DEC;
				end else begin
					if (!rd_data_s1[0] && ({4'b0, hdr_size} >= need_q)
					    && (!found_q || hdr_size < bsize_q)) begin
						found_d = 1'b1;
						best_d  = cur_q;
						bsize_d = hdr_size;
						bprev_d = rd_data_s1[1];
					end
					if (next_off >= {1'b0, region_used}) begin
						state_d = ST_A_DEC;
					end else begin
						rd_off = next_off[OFF_W-1:0];
						cur_d  = next_off[OFF_W-1:0];
					end
				end
			end
			ST_A_DEC: begin
				if (!found_q) begin
					fin        = 1'b1;
					fin_status = STS_NO_SPACE;
					state_d    = ST_IDLE;
				end else if (rem >= MIN_BLOCK) begin
					state_d = ST_A_S0;
				end else begin
					state_d = ST_A_J0;
				end
			end
			ST_A_S0: begin
				wr_en   = 1'b1;
				wr_off  = best_q;
				wr_data = need_q[OFF_W-1:0] | WORD_W'(1) | {11'b0, bprev_q, 1'b0};
				state_d = ST_A_S1;
			end
			ST_A_S1: begin
				wr_en   = 1'b1;
				wr_off  = best_q + need_q[OFF_W-1:0];
				wr_data = rem | WORD_W'(2);
				state_d = ST_A_S2;
			end
			ST_A_S2: begin
				wr_en    = 1'b1;
				wr_off   = best_q + bsize_q - HDR_BYTES;
				wr_data  = rem;
				fin      = 1'b1;
				fin_addr = 12'(best_q + HDR_BYTES);
				state_d  = ST_IDLE;
			end
			ST_A_J0: begin
				wr_en   = 1'b1;
				wr_off  = best_q;
				wr_data = bsize_q | WORD_W'(1) | {11'b0, bprev_q, 1'b0};
				rd_off  = nx_off[OFF_W-1:0];
				if (nx_off < {1'b0, region_used}) begin
					state_d = ST_A_JN;
				end else begin
					fin      = 1'b1;
					fin_addr = 12'(best_q + HDR_BYTES);
					state_d  = ST_IDLE;
				end
			end
			ST_A_JN: begin
				// set previous-busy on the following block
				wr_en    = 1'b1;
				wr_off   = nx_off[OFF_W-1:0];
				wr_data  = rd_data_s1 | WORD_W'(2);
				fin      = 1'b1;
				fin_addr = 12'(best_q + HDR_BYTES);
				state_d  = ST_IDLE;
			end
			ST_WALK_F: begin
				if (hdr_bad) begin
					fin        = 1'b1;
					fin_status = STS_BAD_PTR;
					state_d    = ST_IDLE;
				end else if (cur_q == h_q) begin
					if (rd_data_s1[0]) begin
						size_d  = hdr_size;
						pbits_d = rd_data_s1[1];
						rd_off  = next_off[OFF_W-1:0];
						if (next_off < {1'b0, region_used})
							state_d = ST_F_NX;
						else
							state_d = ST_F_PRV;
					end else begin
						fin        = 1'b1;
						fin_status = STS_BAD_PTR;
						state_d    = ST_IDLE;
					end
				end else begin
					prev_d  = cur_q;
					havep_d = 1'b1;
					pfree_d = !rd_data_s1[0];
					ppb_d   = rd_data_s1[1];
					if ((next_off >= {1'b0, region_used}) || (next_off > {1'b0, h_q})) begin
						fin        = 1'b1;
						fin_status = STS_BAD_PTR;
						state_d    = ST_IDLE;
					end else begin
						rd_off = next_off[OFF_W-1:0];
						cur_d  = next_off[OFF_W-1:0];
					end
				end
			end
			ST_F_NX: begin
				// merge with a free follower, else clear its previous-busy bit
				if ((hdr_size >= MIN_BLOCK)
				    && (nx_off + {1'b0, hdr_size} <= {1'b0, region_used})
				    && !rd_data_s1[0]) begin
					size_d = size_q + hdr_size;
				end else begin
					wr_en   = 1'b1;
					wr_off  = nx_off[OFF_W-1:0];
					wr_data = rd_data_s1 & ~WORD_W'(2);
				end
				state_d = ST_F_PRV;
			end
			ST_F_PRV: begin
				if (havep_q && pfree_q) begin
					start_d = prev_q;
					size_d  = size_q + (h_q - prev_q);
					pbits_d = ppb_q;
				end else begin
					start_d = h_q;
				end
				state_d = ST_F_W0;
			end
			ST_F_W0: begin
				wr_en   = 1'b1;
				wr_off  = start_q;
				wr_data = size_q | {11'b0, pbits_q, 1'b0};
				state_d = ST_F_W1;
			end
			ST_F_W1: begin
				wr_en   = 1'b1;
				wr_off  = start_q + size_q - HDR_BYTES;
				wr_data = size_q;
				fin     = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT_H;
			region_q <= REGION_RESET;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			region_q <= region_d;
			done_q   <= fin;
		end
	end

	// datapath registers hold without reset
	always_ff @(posedge clk) begin
		need_q   <= need_d;
		h_q      <= h_d;
		cur_q    <= cur_d;
		found_q  <= found_d;
		best_q   <= best_d;
		bsize_q  <= bsize_d;
		bprev_q  <= bprev_d;
		prev_q   <= prev_d;
		havep_q  <= havep_d;
		pfree_q  <= pfree_d;
		ppb_q    <= ppb_d;
		size_q   <= size_d;
		start_q  <= start_d;
		pbits_q  <= pbits_d;
		if (fin) begin
			raddr_q  <= fin_addr;
			status_q <= fin_status;
		end
	end

	// heap RAM: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en)
			heap_mem[wr_off[AW+1:2]] <= wr_data;
		rd_data_s1 <= heap_mem[rd_off[AW+1:2]];
	end

	assign busy        = (state_q != ST_IDLE) || cfg_valid;
	assign cfg_ready   = (state_q == ST_IDLE);
	assign done        = done_q;
	assign result_addr = raddr_q;
	assign status      = status_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE)
		else $error("result strobe outside idle");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q != ST_IDLE)
		else $error("heap write while idle");

	a_walk_in_region: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK_A || state_q == ST_WALK_F) |-> cur_q < region_used)
		else $error("walk left the region");

	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done_q))
		else $error("accepted item produced nothing");

endmodule

@@ bench/best_fit_heap_allocator_unit_tb.sv @@
`timescale 1ns / 1ps

module best_fit_heap_allocator_unit_tb;
	import bfha_pkg::*;

	localparam int MEM_WORDS = 1024;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic operation = 1'b0;
	logic [15:0] request_bytes = '0;
	logic [11:0] payload_addr = '0;
	logic cfg_valid = 1'b0;
	logic [12:0] region_bytes = '0;
	logic busy, done, cfg_ready;
	logic [11:0] result_addr;
	logic [1:0] status;

	typedef struct packed {
		logic [11:0] addr;
		status_t sts;
	} outcome_t;

	// predicted heap image and settings
	logic [12:0] heap_img [MEM_WORDS];
	int unsigned region_used;
	outcome_t pending_outcomes[$];
	// payload offsets currently held, used to build well-formed frees
	int unsigned live_ptrs[$];

	int mismatches = 0;
	int items_sent = 0;
	int results_seen = 0;
	int allocs_ok = 0;
	int frees_ok = 0;
	int idle_cycles = 0;
	bit timed_out = 0;

	best_fit_heap_allocator_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .request_bytes(request_bytes),
		.payload_addr(payload_addr), .done(done), .result_addr(result_addr),
		.status(status), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.region_bytes(region_bytes)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned heap_rd(int unsigned off);
		if ((off >> 2) >= MEM_WORDS) return 0;
		return {19'd0, heap_img[off >> 2]};
	endfunction

	function automatic void heap_wr(int unsigned off, int unsigned v);
		if ((off >> 2) < MEM_WORDS) heap_img[off >> 2] = v[12:0];
	endfunction

	function automatic void heap_format(logic [12:0] req_region);
		int unsigned r;
		r = {19'd0, req_region & ~13'd3};
		if (r < 8) r = 8;
		if (r > MEM_WORDS * 4) r = MEM_WORDS * 4;
		if (r > 4096) r = 4096;
		region_used = r;
		foreach (heap_img[i]) heap_img[i] = '0;
		heap_wr(0, r | 2);
		heap_wr(r - 4, r);
		live_ptrs.delete();
	endfunction

	// size of the block at off, 0 where the header is damaged
	function automatic int unsigned block_len(int unsigned off);
		int unsigned s;
		s = heap_rd(off) & ~32'd3;
		if (s < 8 || s > region_used - off) return 0;
		return s;
	endfunction

	function automatic outcome_t heap_allocate(int unsigned req);
		outcome_t o;
		int unsigned need, off, s, best, best_len, h, rem, nx;
		bit found;
		o.addr = '0;
		o.sts = STS_OK;
		found = 0;
		best = 0;
		best_len = 0;
		if (req == 0) begin
			o.sts = STS_BAD_SIZE;
			return o;
		end
		need = ((req + 3) & ~32'd3) + 4;
		off = 0;
		while (off < region_used) begin
			s = block_len(off);
			if (s == 0) break;
			if ((heap_rd(off) & 1) == 0 && s >= need && (!found || s < best_len)) begin
				found = 1;
				best = off;
				best_len = s;
			end
			off += s;
		end
		if (!found) begin
			o.sts = STS_NO_SPACE;
			return o;
		end
		h = heap_rd(best) & 2;
		if (best_len - need >= 8) begin
			rem = best_len - need;
			heap_wr(best, need | 1 | h);
			heap_wr(best + need, rem | 2);
			heap_wr(best + best_len - 4, rem);
		end else begin
			nx = best + best_len;
			heap_wr(best, best_len | 1 | h);
			if (nx < region_used) heap_wr(nx, heap_rd(nx) | 2);
		end
		o.addr = 12'((best + 4) & 32'hFFF);
		return o;
	endfunction

	function automatic outcome_t heap_release(int unsigned p);
		outcome_t o;
		int unsigned h, off, s, prv, len, base, pbits, nx, ns;
		bit have_prv, hit;
		o.addr = '0;
		o.sts = STS_BAD_PTR;
		have_prv = 0;
		hit = 0;
		prv = 0;
		if (p == 0 || (p & 3) != 0 || p < 4 || p >= region_used) return o;
		h = p - 4;
		off = 0;
		while (off < region_used && off <= h) begin
			s = block_len(off);
			if (s == 0) break;
			if (off == h) begin
				hit = 1;
				break;
			end
			prv = off;
			have_prv = 1;
			off += s;
		end
		if (!hit || (heap_rd(h) & 1) == 0) return o;
		len = block_len(h);
		base = h;
		pbits = heap_rd(h) & 2;
		nx = h + len;
		if (nx < region_used) begin
			ns = block_len(nx);
			if (ns != 0 && (heap_rd(nx) & 1) == 0) len += ns;
			else heap_wr(nx, heap_rd(nx) & ~32'd2);
		end
		if (have_prv && (heap_rd(prv) & 1) == 0) begin
			pbits = heap_rd(prv) & 2;
			len += h - prv;
			base = prv;
		end
		heap_wr(base, len | pbits);
		heap_wr(base + len - 4, len);
		o.sts = STS_OK;
		return o;
	endfunction

	// random gap: mostly short, now and then long, sometimes none
	task automatic idle_gap();
		int n;
		n = $urandom_range(0, 99);
		if (n < 40) n = 0;
		else if (n < 92) n = $urandom_range(1, 3);
		else n = $urandom_range(10, 40);
		// with no gap, start stays high for the next item
		if (n != 0) begin
			start <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// issue one command item, hold until the block takes it, then predict it
	task automatic send_command(op_t op, logic [15:0] req, logic [11:0] ptr);
		outcome_t o;
		int idx;
		operation <= op;
		request_bytes <= req;
		payload_addr <= ptr;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (op == OP_ALLOC) o = heap_allocate({16'd0, req});
		else o = heap_release({20'd0, ptr});
		pending_outcomes.push_back(o);
		items_sent++;
		if (op == OP_ALLOC && o.sts == STS_OK) begin
			live_ptrs.push_back({20'd0, o.addr});
			allocs_ok++;
		end
		if (op == OP_FREE && o.sts == STS_OK) begin
			frees_ok++;
			for (idx = 0; idx < live_ptrs.size(); idx++)
				if (live_ptrs[idx] == {20'd0, ptr}) begin
					live_ptrs.delete(idx);
					break;
				end
		end
		@(negedge clk);
		idle_gap();
	endtask

	// wait out outstanding results, then let the block settle
	task automatic drain();
		start <= 1'b0;
		while (pending_outcomes.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_region(logic [12:0] v);
		drain();
		region_bytes <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		heap_format(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
		region_bytes <= 13'($urandom);
	endtask

	task automatic free_random_live();
		int k;
		k = $urandom_range(0, live_ptrs.size() - 1);
		send_command(OP_FREE, 16'($urandom), 12'(live_ptrs[k]));
	endtask

	// extremes of the fields and each rejection path
	task automatic test_directed();
		send_command(OP_ALLOC, 16'd0, 12'd0);
		send_command(OP_ALLOC, 16'hFFFF, 12'hFFF);
		send_command(OP_ALLOC, 16'd4092, 12'd0);
		send_command(OP_FREE, 16'd0, 12'd4);
		send_command(OP_ALLOC, 16'd1, 12'd0);
		send_command(OP_ALLOC, 16'd5, 12'd0);
		send_command(OP_ALLOC, 16'd12, 12'd0);
		send_command(OP_FREE, 16'hFFFF, 12'd0);
		send_command(OP_FREE, 16'd0, 12'd6);
		send_command(OP_FREE, 16'd0, 12'hFFC);
		send_command(OP_FREE, 16'd0, 12'd12);
		send_command(OP_FREE, 16'd0, 12'd4);
		send_command(OP_FREE, 16'd0, 12'd4);
		send_command(OP_FREE, 16'd0, 12'd12);
		send_command(OP_FREE, 16'd0, 12'd24);
		send_command(OP_ALLOC, 16'd4000, 12'd0);
		send_command(OP_ALLOC, 16'd3, 12'd0);
		set_region(13'd8);
		send_command(OP_ALLOC, 16'd4, 12'd0);
		send_command(OP_ALLOC, 16'd1, 12'd0);
		send_command(OP_FREE, 16'd0, 12'd4);
		set_region(13'd3);
		send_command(OP_ALLOC, 16'd4, 12'd0);
		set_region(13'h1FFF);
		send_command(OP_ALLOC, 16'd4088, 12'd0);
		send_command(OP_FREE, 16'd0, 12'd4);
	endtask

	// mostly legal alloc/free traffic with a slice of noise
	task automatic test_random(int n, logic [12:0] region, int max_req);
		int k, r;
		set_region(region);
		for (k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				send_command(OP_ALLOC, 16'($urandom_range(1, max_req)), 12'($urandom));
			else if (r < 80 && live_ptrs.size() != 0)
				free_random_live();
			else if (r < 88)
				send_command(OP_ALLOC, 16'($urandom), 12'($urandom));
			else if (r < 92)
				send_command(OP_ALLOC, 16'd0, 12'($urandom));
			else
				send_command(OP_FREE, 16'($urandom), 12'($urandom));
		end
	endtask

	// result checker: compare each strobe with the oldest prediction
	always @(posedge clk) begin
		outcome_t want;
		if (done) begin
			results_seen++;
			if (pending_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result addr=%0d status=%0d", result_addr, status);
			end else begin
				want = pending_outcomes.pop_front();
				if (result_addr !== want.addr || status !== want.sts) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected addr=%0d status=%0d, got addr=%0d status=%0d",
							results_seen, want.addr, want.sts, result_addr, status);
				end
			end
		end
	end

	// watchdog: count cycles in which nothing moves
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("timeout");
			$display("[best_fit_heap_allocator_unit] ERROR");
			$finish;
		end
	end

	initial begin
		heap_format(13'd4096);
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(300, 13'd4096, 300);
		test_random(250, 13'd64, 40);
		test_random(300, 13'd512, 64);
		test_random(150, 13'd4096, 20);
		test_random(150, 13'd1000, 200);
		drain();
		if (pending_outcomes.size() != 0) mismatches++;
		$display("covered %0d items (%0d allocations, %0d frees granted) over several region sizes",
			items_sent, allocs_ok, frees_ok);
		if (mismatches == 0) $display("[best_fit_heap_allocator_unit] OK");
		else $display("[best_fit_heap_allocator_unit] ERROR");
		$finish;
	end

endmodule

@@ best_fit_heap_allocator_unit.f @@
sv/bfha_pkg.sv
sv/best_fit_heap_allocator_unit.sv
bench/best_fit_heap_allocator_unit_tb.sv
